[sv/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int SYMBOL_BITS = 16;

    localparam int PTR_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W   = 16;
    localparam int IDX_W   = 6;
    localparam int OFS_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    localparam logic [CFG_A_W-1:0] CFG_WILDCARD = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_LENGTH   = 2'd1;

    localparam logic [SYM_W-1:0] WILDCARD_RESET = '1;
    localparam logic [LEN_W-1:0] LENGTH_RESET   = LEN_W'(1);

    typedef struct packed {
        logic pat_wr;
        logic txt_wr;
        logic restart;
        logic rd_en;
        logic res_load;
    } wpm_cmd_t;

    typedef struct packed {
        logic full_next;
        logic scan_last;
        logic out_stall;
    } wpm_status_t;

endpackage

[sv/wpm_if.sv]
// ----------------------------------------------------------------------------
// wpm interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface wpm_item_if;
    import wpm_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   pattern_index;
    logic [SYM_W-1:0]   symbol;

    modport source (output valid, opcode, pattern_index, symbol, input ready);
    modport sink   (input valid, opcode, pattern_index, symbol, output ready);
endinterface

interface wpm_result_if;
    import wpm_pkg::*;

    logic               valid;
    logic               ready;
    logic               match;
    logic [OFS_W-1:0]   start_position;

    modport source (output valid, match, start_position, input ready);
    modport sink   (input valid, match, start_position, output ready);
endinterface

interface wpm_cfg_if;
    import wpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_A_W-1:0]   index;
    logic [CFG_D_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/wpm_ctrl.sv]
// ----------------------------------------------------------------------------
// wpm_ctrl
// Sequencer: takes requests, walks the pattern over the window, hands off
// the result to the output register.
// ----------------------------------------------------------------------------
module wpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_opcode,
    input  wpm_pkg::wpm_status_t  status,
    output wpm_pkg::wpm_cmd_t     cmd
);
    import wpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    opcode_t op;
    logic    accept;

    assign op       = opcode_t'(in_opcode);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_LOAD:    cmd.pat_wr  = 1'b1;
                        OP_RESTART: cmd.restart = 1'b1;
                        OP_TEXT:
                        begin
                            cmd.txt_wr = 1'b1;
                            if (status.full_next)
                                state_next = S_SCAN;
                        end
                        default:    ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // last compare lands this cycle; wait for a free output register
                if (!status.out_stall)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/wpm_datapath.sv]
// ----------------------------------------------------------------------------
// wpm_datapath
// Pattern and text memories, counters, compare-and-accumulate, registers
// and the output register.
// ----------------------------------------------------------------------------
module wpm_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [wpm_pkg::IDX_W-1:0] in_pattern_index,
    input  logic [wpm_pkg::SYM_W-1:0] in_symbol,
    wpm_cfg_if.sink               cfg,
    wpm_result_if.source          result,
    input  wpm_pkg::wpm_cmd_t     cmd,
    output wpm_pkg::wpm_status_t  status
);
    import wpm_pkg::*;

    logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
    logic [SYM_W-1:0] txt_mem [MAX_PATTERN];

    logic [SYM_W-1:0] wildcard_reg;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] seen_reg;
    logic [OFS_W-1:0] next_start_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] idx_reg;
    logic [PTR_W-1:0] base_reg;
    logic [OFS_W-1:0] start_reg;
    logic             cmp_valid_reg;
    logic             acc_reg;
    logic             acc_next;
    logic             out_valid_reg;
    logic             out_match_reg;
    logic [OFS_W-1:0] out_start_reg;
    logic [SYM_W-1:0] pat_rd_reg;
    logic [SYM_W-1:0] txt_rd_reg;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] seen_inc;
    logic [SYM_W-1:0] wc;
    logic             cmp_ok;
    logic [PTR_W-1:0] txt_rd_addr;

    // zero acts as one, anything past the store depth as the full depth
    always_comb
    begin
        if (length_reg == '0)
            len_eff = LEN_W'(1);
        else if (length_reg > LEN_W'(MAX_PATTERN))
            len_eff = LEN_W'(MAX_PATTERN);
        else
            len_eff = length_reg;
    end

    assign seen_inc = (seen_reg < LEN_W'(MAX_PATTERN)) ? seen_reg + LEN_W'(1) : seen_reg;
    assign wc       = wildcard_reg & SYM_W'({SYMBOL_BITS{1'b1}});
    assign cmp_ok   = (pat_rd_reg == wc) || (txt_rd_reg == wc) || (pat_rd_reg == txt_rd_reg);
    assign acc_next = cmp_valid_reg ? (acc_reg && cmp_ok) : acc_reg;
    assign txt_rd_addr = base_reg + idx_reg;

    assign status.full_next = (seen_inc >= len_eff);
    assign status.scan_last = ({1'b0, idx_reg} == (len_eff - LEN_W'(1)));
    assign status.out_stall = out_valid_reg && !result.ready;

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.match          = out_match_reg;
    assign result.start_position = out_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wildcard_reg   <= WILDCARD_RESET;
            length_reg     <= LENGTH_RESET;
            seen_reg       <= '0;
            next_start_reg <= '0;
            head_reg       <= '0;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            acc_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == CFG_WILDCARD)
                    wildcard_reg <= cfg.data;
                else if (cfg.index == CFG_LENGTH)
                    length_reg <= cfg.data[LEN_W-1:0];
            end

            if (cmd.restart)
            begin
                seen_reg       <= '0;
                next_start_reg <= '0;
            end
            else if (cmd.txt_wr)
            begin
                seen_reg       <= seen_inc;
                next_start_reg <= next_start_reg + OFS_W'(1);
                head_reg       <= head_reg + PTR_W'(1);
            end

            if (cmd.txt_wr)
                idx_reg <= '0;
            else if (cmd.rd_en)
                idx_reg <= idx_reg + PTR_W'(1);

            cmp_valid_reg <= cmd.rd_en;

            if (cmd.txt_wr)
                acc_reg <= 1'b1;
            else
                acc_reg <= acc_next;

            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.txt_wr)
        begin
            // oldest symbol of the window ending at the new one
            base_reg  <= head_reg + PTR_W'(1) - len_eff[PTR_W-1:0];
            start_reg <= next_start_reg + OFS_W'(1) - OFS_W'(len_eff);
        end
        if (cmd.res_load)
        begin
            out_match_reg <= acc_next;
            out_start_reg <= start_reg;
        end
    end

    // pattern store
    always_ff @(posedge clk)
    begin
        if (cmd.pat_wr && (int'(in_pattern_index) < MAX_PATTERN))
            pat_mem[in_pattern_index[PTR_W-1:0]] <= in_symbol & SYM_W'({SYMBOL_BITS{1'b1}});
        pat_rd_reg <= pat_mem[idx_reg];
    end

    // text window, circular
    always_ff @(posedge clk)
    begin
        if (cmd.txt_wr)
            txt_mem[head_reg] <= in_symbol & SYM_W'({SYMBOL_BITS{1'b1}});
        txt_rd_reg <= txt_mem[txt_rd_addr];
    end

endmodule

[sv/wildcard_pattern_matcher_core.sv]
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// Streaming pattern match with a wildcard symbol, one compare per cycle.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                               | accepted when
//  item_in   | in  | opcode, pattern_index, symbol         | valid && ready
//  result    | out | match, start_position                 | valid && ready
//  cfg       | in  | index (0 wildcard, 1 length), data    | valid && ready
//
//  loads, restarts and text symbols that fill no window leave the sequencer idle
//  a text symbol with a result goes through the scan and finish states: one compare
//  a cycle through the single read port of each symbol memory
//  the result waits in an output register; a stalled result only holds the
//  next text symbol with a result in its finish state, loads go through until then
//  reset clears the counters and sets the wildcard and length registers to their defaults; the memories are not cleared
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core (
    input  logic          clk,
    input  logic          rst_n,
    wpm_item_if.sink      item_in,
    wpm_result_if.source  result,
    wpm_cfg_if.sink       cfg
);
    import wpm_pkg::*;

    wpm_cmd_t    cmd;
    wpm_status_t status;

    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .in_opcode (item_in.opcode),
        .status    (status),
        .cmd       (cmd)
    );

    wpm_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_pattern_index (item_in.pattern_index),
        .in_symbol        (item_in.symbol),
        .cfg              (cfg),
        .result           (result),
        .cmd              (cmd),
        .status           (status)
    );

`ifndef NO_ASSERTIONS
    // a request that is not a text symbol never yields a result
    a_no_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready && !result.valid
         && (item_in.opcode != OP_TEXT)) |=> !result.valid)
        else $error("result raised after a non-text request");

    // output register only fills from the sequencer
    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.res_load))
        else $error("result valid without a load");

    // never overwrite a waiting result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(result.valid && !result.ready))
        else $error("waiting result overwritten");

    // no request is taken while the window is being scanned
    a_busy_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !item_in.ready)
        else $error("request taken during scan");
`endif

endmodule

[tb/sv/wildcard_pattern_matcher_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core_tb
// Drives pattern loads, text symbols, restarts and register writes into the
// matcher with random idling and a long result hold-off. Every result is
// checked against a local model of the sliding window and the wildcard rule.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core_tb;
    import wpm_pkg::*;

    localparam int IDLE_PCT       = 18;
    localparam int DRAIN_CYCLES   = MAX_PATTERN + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [CFG_A_W-1:0] CFG_SPARE_LO = CFG_A_W'(2);
    localparam logic [CFG_A_W-1:0] CFG_SPARE_HI = CFG_A_W'(3);

    typedef struct packed {
        logic             hit;
        logic [OFS_W-1:0] start;
    } match_result_t;

    logic clk;
    logic rst_n;

    wpm_item_if   item_if ();
    wpm_result_if res_if ();
    wpm_cfg_if    cfg_if ();

    wildcard_pattern_matcher_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_if),
        .result  (res_if),
        .cfg     (cfg_if)
    );

    // local copy of the matcher state
    logic [SYM_W-1:0] pattern_copy [MAX_PATTERN];
    logic [SYM_W-1:0] text_hist [MAX_PATTERN];
    logic [LEN_W-1:0] text_count   = '0;
    logic [OFS_W-1:0] next_offset  = '0;
    logic [SYM_W-1:0] cur_wildcard = WILDCARD_RESET;
    logic [LEN_W-1:0] cur_length   = LENGTH_RESET;

    match_result_t match_queue [$];

    int mismatches    = 0;
    int stall_cycles  = 0;
    int src_idle_pct  = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;
    int sink_hold     = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int eff_length();
        if (cur_length == 0)
            return 1;
        if (cur_length > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(cur_length);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_match(input opcode_t op, input logic [IDX_W-1:0] idx,
                                 input logic [SYM_W-1:0] sym);
        int len;
        int k;
        logic [OFS_W-1:0] first;
        match_result_t r;
        len = eff_length();
        case (op)
            OP_LOAD:
                pattern_copy[idx] = sym;
            OP_RESTART:
            begin
                text_count  = '0;
                next_offset = '0;
            end
            OP_TEXT:
            begin
                first = next_offset;
                for (k = MAX_PATTERN - 1; k > 0; k--)
                    text_hist[k] = text_hist[k-1];
                text_hist[0] = sym;
                if (text_count < MAX_PATTERN)
                    text_count++;
                next_offset++;
                if (text_count >= len)
                begin
                    r.hit = 1'b1;
                    for (k = 0; k < len; k++)
                        if (pattern_copy[k] != cur_wildcard &&
                            text_hist[len-1-k] != cur_wildcard &&
                            pattern_copy[k] != text_hist[len-1-k])
                            r.hit = 1'b0;
                    r.start = OFS_W'(int'(first) + 1 - len);
                    match_queue.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // one request on the item channel; valid stays high unless an idle cycle follows
    task automatic send_item(input opcode_t op, input logic [IDX_W-1:0] idx,
                             input logic [SYM_W-1:0] sym);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid         <= 1'b1;
        item_if.opcode        <= op;
        item_if.pattern_index <= idx;
        item_if.symbol        <= sym;
        @(posedge clk);
        while (item_if.ready !== 1'b1)
            @(posedge clk);
        predict_match(op, idx, sym);
        @(negedge clk);
    endtask

    task automatic send_text(input logic [SYM_W-1:0] sym);
        send_item(OP_TEXT, IDX_W'($urandom), sym);
    endtask

    task automatic send_restart();
        send_item(OP_RESTART, IDX_W'($urandom), SYM_W'($urandom));
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (match_queue.size() != 0)
            @(negedge clk);
        // loads and restarts may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_WILDCARD: cur_wildcard = data[SYM_W-1:0];
            CFG_LENGTH:   cur_length   = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [CFG_D_W-1:0] wc_data,
                                 input logic [CFG_D_W-1:0] len_data, input bit spare);
        wait_idle();
        if (spare)
            write_reg(CFG_SPARE_LO, CFG_D_W'($urandom));
        write_reg(CFG_WILDCARD, wc_data);
        if (spare)
            write_reg(CFG_SPARE_HI, CFG_D_W'($urandom));
        write_reg(CFG_LENGTH, len_data);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_pattern_load();
        int k;
        logic [SYM_W-1:0] sym;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            if (k == 0)
                sym = '0;
            else if (k == 1)
                sym = '1;
            else
                sym = SYM_W'($urandom);
            send_item(OP_LOAD, IDX_W'(k), sym);
        end
    endtask

    task automatic test_reset_defaults();
        send_text(pattern_copy[0]);
        send_text(pattern_copy[0] ^ 16'h8001);
        send_text(WILDCARD_RESET);
        send_item(OP_NOP, '1, '1);
        send_restart();
        send_text(16'h7FFE);
    endtask

    task automatic test_special_cases();
        set_registers(16'h00A5, CFG_D_W'(3), 1'b1);
        send_item(OP_LOAD, IDX_W'(0), 16'h1111);
        send_item(OP_LOAD, IDX_W'(1), 16'h00A5);
        send_item(OP_LOAD, IDX_W'(2), 16'h3333);
        send_restart();
        // first two symbols leave the window short
        send_text(16'h1111);
        send_text(16'h9999);
        send_text(16'h3333);
        send_text(16'h00A5);
        send_item(OP_NOP, '0, '1);
        send_text(16'h1111);
        send_text(16'h00A5);
        send_text(16'h3334);
        // masked length of zero behaves as one
        set_registers(WILDCARD_RESET, 16'hFF80, 1'b0);
        send_text(16'h1111);
        send_text(16'h0000);
        send_text(16'hFFFF);
        set_registers(16'h3333, CFG_D_W'(2), 1'b1);
        send_restart();
        send_text(16'h5555);
        send_text(16'h3333);
        send_text(16'h1111);
        send_text(16'h0000);
    endtask

    task automatic test_backpressure();
        int k;
        set_registers(CFG_D_W'($urandom), CFG_D_W'(2), 1'b0);
        // receiver holds off while requests keep coming
        sink_hold = HOLD_CYCLES;
        for (k = 0; k < 16; k++)
            send_text(pattern_copy[k % 2]);
    endtask

    task automatic test_random_traffic();
        int phase;
        int budget;
        int done;
        int len;
        int k;
        int pick;
        logic [CFG_D_W-1:0] len_data;
        logic [CFG_D_W-1:0] wc_data;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        for (phase = 0; phase < 9; phase++)
        begin
            base = SYM_W'($urandom);
            if (phase == 3)
                len_data = {9'($urandom), 7'h7F};
            else if (phase == 8)
                len_data = CFG_D_W'(MAX_PATTERN);
            else
                len_data = {9'($urandom), 7'($urandom_range(8))};
            case (phase % 4)
                0:       wc_data = CFG_D_W'($urandom);
                1:       wc_data = '1;
                2:       wc_data = '0;
                default: wc_data = base ^ 16'h0003;
            endcase
            set_registers(wc_data, len_data, phase % 3 == 0);
            len = eff_length();
            budget = (len > 16) ? 100 : 70;
            // fresh pattern, mostly from a four-symbol alphabet, with the odd wildcard or random symbol
            for (k = 0; k < len; k++)
            begin
                pick = $urandom_range(19);
                if (pick == 0)
                    sym = cur_wildcard;
                else if (pick == 1)
                    sym = SYM_W'($urandom);
                else
                    sym = base ^ SYM_W'($urandom_range(3));
                send_item(OP_LOAD, IDX_W'(k), sym);
            end
            done = len;
            if ($urandom_range(1))
            begin
                send_restart();
                done++;
            end
            while (done < budget)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // planted copy of the pattern, lightly disturbed
                    for (k = 0; k < len; k++)
                    begin
                        case ($urandom_range(len * 4))
                            0:       sym = SYM_W'($urandom);
                            1:       sym = base ^ SYM_W'($urandom_range(3));
                            2:       sym = cur_wildcard;
                            default: sym = pattern_copy[k];
                        endcase
                        send_text(sym);
                    end
                    done += len;
                end
                else if (pick < 80)
                begin
                    send_text(base ^ SYM_W'($urandom_range(3)));
                    done++;
                end
                else if (pick < 87)
                begin
                    if ($urandom_range(1))
                        k = $urandom_range(len - 1);
                    else
                        k = $urandom_range(MAX_PATTERN - 1);
                    send_item(OP_LOAD, IDX_W'(k), base ^ SYM_W'($urandom_range(3)));
                    done++;
                end
                else if (pick < 91)
                begin
                    send_restart();
                    done++;
                end
                else if (pick < 95)
                begin
                    send_text(SYM_W'($urandom));
                    done++;
                end
                else
                    send_item(OP_NOP, IDX_W'($urandom), SYM_W'($urandom));
            end
        end
    endtask

    task automatic test_no_idle_burst();
        int k;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_registers(CFG_D_W'($urandom), CFG_D_W'(3), 1'b0);
        send_restart();
        for (k = 0; k < 36; k++)
            send_text($urandom_range(1) ? pattern_copy[k % 3] : SYM_W'($urandom));
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // result receiver
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                res_if.ready <= 1'b0;
                sink_hold--;
            end
            else
                res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (match_queue.size() == 0)
                report_mismatch($sformatf("unexpected result match=%0b start=%0d",
                                          res_if.match, res_if.start_position));
            else
            begin
                want = match_queue.pop_front();
                if (res_if.match !== want.hit)
                    report_mismatch($sformatf("match got %0b want %0b (start %0d)",
                                              res_if.match, want.hit, want.start));
                if (res_if.start_position !== want.start)
                    report_mismatch($sformatf("start_position got %0d want %0d",
                                              res_if.start_position, want.start));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", stall_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        item_if.valid         = 1'b0;
        item_if.opcode        = OP_NOP;
        item_if.pattern_index = '0;
        item_if.symbol        = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = CFG_WILDCARD;
        cfg_if.data           = '0;
        rst_n                 = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pattern_load();
        test_reset_defaults();
        test_special_cases();
        test_backpressure();
        test_random_traffic();
        test_no_idle_burst();

        wait_idle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
